// File: src/cibs_pkg.sv
package cibs_pkg;

    localparam int MAX_NEEDLE  = 16;
    localparam int OFFSET_BITS = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 64;
    localparam int LEN_W       = 5;
    localparam int OFFSET_W    = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int IDX_W       = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = 2'd2;

    localparam logic [BYTE_W-1:0] LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_DIFF = 8'h20;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } hs_item_t;

    // ASCII a..z to A..Z, everything else untouched
    function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= LOWER_A && b <= LOWER_Z)
        begin
            r = b - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

// File: src/cibs_front.sv
module cibs_front
    import cibs_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              last_byte,
    input  logic              queue_full,
    output logic              push,
    output hs_item_t          push_item
);

    // fold on the way in so the back end never sees lower-case ASCII letters
    assign in_stall       = queue_full;
    assign push           = in_valid && !queue_full;
    assign push_item.data = fold_upper(data_byte);
    assign push_item.last = last_byte;

endmodule

// File: src/cibs_queue.sv
module cibs_queue
    import cibs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hs_item_t push_item,
    input  logic     pop,
    output logic     head_valid,
    output hs_item_t head_item,
    output logic     full
);

    hs_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/cibs_back.sv
module cibs_back
    import cibs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [WORD_W-1:0]      write_data,
    input  logic                   head_valid,
    input  hs_item_t               head_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [OFFSET_W-1:0]    match_offset
);

    logic [WORD_W-1:0]      needle_low_reg;
    logic [WORD_W-1:0]      needle_high_reg;
    logic [LEN_W-1:0]       needle_length_reg;
    logic [BYTE_W-1:0]      window_reg [MAX_NEEDLE-1];
    logic [BYTE_W-1:0]      window_next [MAX_NEEDLE-1];
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic                   reported_reg;
    logic                   reported_next;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [OFFSET_W-1:0]    offset_reg;

    logic [2*WORD_W-1:0]    needle_all;
    logic [BYTE_W-1:0]      seq [MAX_NEEDLE];
    logic [OFFSET_BITS-1:0] count_inc;
    logic [OFFSET_BITS-1:0] offset_full;
    logic                   len_ok;
    logic                   hit;
    logic                   emit_found;
    logic                   emit_none;
    logic                   out_free;

    assign out_free     = !out_valid_reg || !out_stall;
    assign pop          = head_valid && out_free;
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;
    assign needle_all   = {needle_high_reg, needle_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_NEEDLE - 1; i++)
        begin
            seq[i] = window_reg[i];
        end
        seq[MAX_NEEDLE-1] = head_item.data;
    end

    // count saturates at all ones
    assign count_inc   = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign offset_full = count_inc - OFFSET_BITS'(needle_length_reg);
    assign len_ok      = (needle_length_reg <= LEN_W'(MAX_NEEDLE));

    // needle byte k lines up with seq[MAX_NEEDLE - len + k]
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        hit = 1'b1;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            pos = LEN_W'(MAX_NEEDLE) - needle_length_reg + LEN_W'(k);
            if (LEN_W'(k) < needle_length_reg &&
                seq[pos[IDX_W-1:0]] != fold_upper(needle_all[k*BYTE_W +: BYTE_W]))
            begin
                hit = 1'b0;
            end
        end
        if (needle_length_reg != '0 && count_inc < OFFSET_BITS'(needle_length_reg))
        begin
            hit = 1'b0;
        end
    end

    assign emit_found = !reported_reg && len_ok && hit;
    assign emit_none  = head_item.last && !reported_reg && !emit_found;

    always_comb
    begin
        if (head_item.last)
        begin
            for (int i = 0; i < MAX_NEEDLE - 1; i++)
            begin
                window_next[i] = '0;
            end
            count_next    = '0;
            reported_next = 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAX_NEEDLE - 1; i++)
            begin
                window_next[i] = seq[i+1];
            end
            count_next    = count_inc;
            reported_next = reported_reg || emit_found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= '0;
            for (int i = 0; i < MAX_NEEDLE - 1; i++)
            begin
                window_reg[i] <= '0;
            end
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_enable)
            begin
                case (write_index)
                    REG_NEEDLE_LOW:    needle_low_reg    <= write_data;
                    REG_NEEDLE_HIGH:   needle_high_reg   <= write_data;
                    REG_NEEDLE_LENGTH: needle_length_reg <= write_data[LEN_W-1:0];
                    default:           ;
                endcase
            end
            if (pop)
            begin
                window_reg   <= window_next;
                count_reg    <= count_next;
                reported_reg <= reported_next;
            end
            if (out_free)
            begin
                out_valid_reg <= pop && (emit_found || emit_none);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            found_reg  <= emit_found;
            offset_reg <= (emit_found && needle_length_reg != '0) ?
                          OFFSET_W'(offset_full) : '0;
        end
    end

endmodule

// File: src/case_insensitive_byte_search.sv
// A byte accepted at the input is written into the queue; when it is popped from
// the queue head, any result it produces is registered in the output register.
// Throughput: one byte per cycle unless out_stall holds the output; the window
// compare is combinational and a two-entry queue decouples input from output stalls.
// Reset (rst_n, asynchronous, active low) clears the needle registers, the
// window, the byte count, the queue and the output valid.
module case_insensitive_byte_search
    import cibs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   write_enable,
    input  logic [CFG_INDEX_W-1:0] write_index,
    input  logic [WORD_W-1:0]      write_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   found,
    output logic [OFFSET_W-1:0]    match_offset
);

    logic     push;
    hs_item_t push_item;
    logic     pop;
    logic     head_valid;
    hs_item_t head_item;
    logic     queue_full;

    cibs_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    cibs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (queue_full)
    );

    cibs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset)
    );

endmodule
